FILE: hw/rtl/bdla_pkg.sv
// ----------------------------------------------------------------------------
// bdla_pkg
// shared types, constants and colour tables of the button debounce and
// led animator block
// ----------------------------------------------------------------------------
package bdla_pkg;

  localparam int unsigned LedCount       = 8;
  localparam int unsigned LedIdxWidth    = $clog2(LedCount);
  localparam int unsigned TimeWidth      = 32;
  localparam int unsigned FrameWidth     = 8;
  localparam int unsigned PeriodWidth    = 9;
  localparam int unsigned TargetWidth    = $clog2(LedCount) + 1;
  localparam int unsigned ColorWidth     = 24;
  localparam int unsigned DebounceWidth  = 10;
  localparam int unsigned LongPressWidth = 14;
  localparam int unsigned AddrWidth      = 3;
  localparam int unsigned DataWidth      = 32;

  typedef enum logic [2:0] {
    OpTick  = 3'd0,
    OpCount = 3'd1,
    OpHit   = 3'd2,
    OpSeek  = 3'd3,
    OpBlank = 3'd4,
    OpHunt  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ModeCount = 3'd0,
    ModeHit   = 3'd1,
    ModeBlank = 3'd2,
    ModeHunt  = 3'd3,
    ModeSeek  = 3'd4
  } mode_e;

  // register index, taken from paddr bit 2
  localparam logic RegDebounce  = 1'b0;
  localparam logic RegLongPress = 1'b1;

  localparam logic [DebounceWidth-1:0]  DebounceReset  = DebounceWidth'(50);
  localparam logic [LongPressWidth-1:0] LongPressReset = LongPressWidth'(1000);

  localparam logic [PeriodWidth-1:0] PeriodCount = PeriodWidth'(100);
  localparam logic [PeriodWidth-1:0] PeriodHit   = PeriodWidth'(200);
  localparam logic [PeriodWidth-1:0] PeriodSeek  = PeriodWidth'(200);
  localparam logic [PeriodWidth-1:0] PeriodBlank = PeriodWidth'(500);
  localparam logic [PeriodWidth-1:0] PeriodHunt  = PeriodWidth'(300);

  localparam logic [FrameWidth-1:0] FrameMax  = FrameWidth'(255);
  localparam logic [FrameWidth-1:0] HuntLast  = FrameWidth'(2);
  localparam logic [FrameWidth-1:0] SeekLast  = FrameWidth'(4);
  localparam logic [FrameWidth-1:0] HitFirst  = FrameWidth'(0);
  localparam logic [FrameWidth-1:0] HitSecond = FrameWidth'(2);

  localparam logic [ColorWidth-1:0] ColRed    = 24'h00FF00;
  localparam logic [ColorWidth-1:0] ColBlue   = 24'h0000FF;
  localparam logic [ColorWidth-1:0] ColYellow = 24'hFFFF00;
  localparam logic [ColorWidth-1:0] ColGreen  = 24'hFF0000;
  localparam logic [ColorWidth-1:0] ColOrange = 24'hA5FF00;
  localparam logic [ColorWidth-1:0] ColPurple = 24'h008080;
  localparam logic [ColorWidth-1:0] ColGrey   = 24'h323232;
  localparam logic [ColorWidth-1:0] ColWhite  = 24'hFFFFFF;
  localparam logic [ColorWidth-1:0] ColDark   = 24'h000000;

  typedef logic [ColorWidth-1:0] pixel_t;
  typedef pixel_t [LedCount-1:0] strip_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic              button_level;
    logic [2:0]        color_select;
    logic signed [7:0] bar_length;
  } in_item_t;

  typedef struct packed {
    logic   short_press;
    logic   long_press;
    logic   strip_updated;
    pixel_t pixel_0;
    pixel_t pixel_1;
    pixel_t pixel_2;
    pixel_t pixel_3;
    pixel_t pixel_4;
    pixel_t pixel_5;
    pixel_t pixel_6;
    pixel_t pixel_7;
  } out_item_t;

  typedef struct packed {
    logic [TimeWidth-1:0] now;
    logic [TimeWidth-1:0] next;
  } stamp_t;

  typedef struct packed {
    logic [DebounceWidth-1:0]  debounce_ms;
    logic [LongPressWidth-1:0] long_press_ms;
  } cfg_t;

  function automatic pixel_t count_color(input logic [2:0] sel);
    pixel_t col;
    case (sel)
      3'd0:    col = ColRed;
      3'd1:    col = ColBlue;
      3'd2:    col = ColYellow;
      3'd3:    col = ColGreen;
      3'd4:    col = ColOrange;
      3'd5:    col = ColPurple;
      default: col = ColGrey;
    endcase
    return col;
  endfunction

  // three led groups: 0..2, 3..4, 5..7
  function automatic pixel_t hunt_color(input logic [1:0] frame,
                                        input logic [LedIdxWidth-1:0] led);
    logic [1:0] grp;
    pixel_t     col;
    if (led < LedIdxWidth'(3)) begin
      grp = 2'd0;
    end else if (led < LedIdxWidth'(5)) begin
      grp = 2'd1;
    end else begin
      grp = 2'd2;
    end
    case ({frame, grp})
      4'b0000: col = ColRed;
      4'b0001: col = ColBlue;
      4'b0010: col = ColOrange;
      4'b0100: col = ColOrange;
      4'b0101: col = ColRed;
      4'b0110: col = ColBlue;
      4'b1000: col = ColBlue;
      4'b1001: col = ColOrange;
      4'b1010: col = ColRed;
      default: col = ColDark;
    endcase
    return col;
  endfunction

endpackage

FILE: hw/rtl/bdla_debounce.sv
// ----------------------------------------------------------------------------
// bdla_debounce
// millisecond time base, button debouncer and short / long press detection
// ----------------------------------------------------------------------------
module bdla_debounce import bdla_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   tick_i,
  input  logic   level_i,
  input  cfg_t   cfg_i,
  output stamp_t time_o,
  output logic   short_press_o,
  output logic   long_press_o
);

  logic [TimeWidth-1:0] time_q, time_d;
  logic [TimeWidth-1:0] change_q, change_d;
  logic [TimeWidth-1:0] hold_q, hold_d;
  logic                 raw_q, raw_d;
  logic                 steady_q, steady_d;
  logic [TimeWidth-1:0] time_inc;
  logic [TimeWidth-1:0] since_change;
  logic [TimeWidth-1:0] since_hold;
  logic                 changed;
  logic                 settled;
  logic                 flip;

  assign time_inc     = time_q + TimeWidth'(1);
  assign since_change = time_inc - change_q;
  assign since_hold   = time_inc - hold_q;
  assign changed      = (level_i != raw_q);
  // a fresh edge restarts the window, so it can never settle on this tick
  assign settled      = !changed &&
                        (since_change > TimeWidth'(cfg_i.debounce_ms));
  assign flip         = tick_i && settled && (steady_q != level_i);

  assign time_o.now  = time_q;
  assign time_o.next = time_inc;

  always_comb begin
    time_d   = time_q;
    change_d = change_q;
    hold_d   = hold_q;
    raw_d    = raw_q;
    steady_d = steady_q;
    short_press_o = 1'b0;
    long_press_o  = 1'b0;
    if (tick_i) begin
      time_d = time_inc;
      if (changed) begin
        change_d = time_inc;
        raw_d    = level_i;
      end
    end
    if (flip) begin
      steady_d = level_i;
      if (!level_i) begin
        short_press_o = 1'b1;
        hold_d        = time_inc;
      end else if (since_hold > TimeWidth'(cfg_i.long_press_ms)) begin
        long_press_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      change_q <= '0;
      hold_q   <= '0;
      raw_q    <= 1'b1;
      steady_q <= 1'b1;
    end else begin
      time_q   <= time_d;
      change_q <= change_d;
      hold_q   <= hold_d;
      raw_q    <= raw_d;
      steady_q <= steady_d;
    end
  end

endmodule

FILE: hw/rtl/bdla_animator.sv
// ----------------------------------------------------------------------------
// bdla_animator
// frame timer, animation mode state and pixel painter for the led strip
// ----------------------------------------------------------------------------
module bdla_animator import bdla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_item_t item_i,
  input  stamp_t   time_i,
  output logic     updated_o,
  output strip_t   pixels_o
);

  mode_e                  mode_q, mode_d;
  logic [FrameWidth-1:0]  frame_q, frame_d;
  logic [TimeWidth-1:0]   fstamp_q, fstamp_d;
  logic [PeriodWidth-1:0] period_q, period_d;
  logic                   pend_q, pend_d;
  pixel_t                 color_q, color_d;
  logic [TargetWidth-1:0] target_q, target_d;
  strip_t                 pixels_q, pixels_d;

  logic                   due;
  logic [FrameWidth-1:0]  frame_adv;
  logic                   pend_adv;
  logic [FrameWidth-1:0]  lit;
  logic [FrameWidth-1:0]  frame_hunt;
  logic [FrameWidth-1:0]  frame_seek;
  logic [TargetWidth-1:0] clamp_len;
  logic                   seek_red;

  assign due = (time_i.next - fstamp_q) >= TimeWidth'(period_q);

  always_comb begin
    frame_adv = frame_q;
    if (due && (frame_q != FrameMax)) begin
      frame_adv = frame_q + FrameWidth'(1);
    end
  end

  assign pend_adv   = pend_q || due;
  assign lit        = (frame_adv > FrameWidth'(target_q)) ? FrameWidth'(target_q)
                                                          : frame_adv;
  assign frame_hunt = (frame_adv > HuntLast) ? '0 : frame_adv;
  assign frame_seek = (frame_adv > SeekLast) ? '0 : frame_adv;

  always_comb begin
    if (item_i.bar_length[7]) begin
      clamp_len = '0;
    end else if (item_i.bar_length[6:0] >= 7'(LedCount)) begin
      clamp_len = TargetWidth'(LedCount);
    end else begin
      clamp_len = item_i.bar_length[TargetWidth-1:0];
    end
  end

  always_comb begin
    mode_d    = mode_q;
    frame_d   = frame_q;
    fstamp_d  = fstamp_q;
    period_d  = period_q;
    pend_d    = pend_q;
    color_d   = color_q;
    target_d  = target_q;
    pixels_d  = pixels_q;
    updated_o = 1'b0;
    seek_red  = 1'b0;
    if (valid_i) begin
      case (op_e'(item_i.operation))
        OpTick: begin
          frame_d = frame_adv;
          pend_d  = pend_adv;
          if (due) begin
            fstamp_d = time_i.next;
          end
          if (pend_adv) begin
            updated_o = 1'b1;
            pend_d    = 1'b0;
            case (mode_q)
              ModeCount: begin
                for (int i = 0; i < LedCount; i++) begin
                  pixels_d[i] = (lit >= FrameWidth'(i + 1)) ? color_q : ColDark;
                end
                pend_d = 1'b1;
              end
              ModeHit: begin
                for (int i = 0; i < LedCount; i++) begin
                  pixels_d[i] = (frame_adv == HitFirst || frame_adv == HitSecond)
                                ? ColYellow : ColDark;
                end
              end
              ModeHunt: begin
                frame_d = frame_hunt;
                for (int i = 0; i < LedCount; i++) begin
                  pixels_d[i] = hunt_color(frame_hunt[1:0], LedIdxWidth'(i));
                end
              end
              ModeSeek: begin
                frame_d = frame_seek;
                for (int i = 0; i < LedCount; i++) begin
                  seek_red = (frame_seek < SeekLast) &&
                             ((frame_seek == FrameWidth'(i)) ||
                              (frame_seek == FrameWidth'(LedCount - 1 - i)));
                  pixels_d[i] = seek_red ? ColRed : ColWhite;
                end
              end
              default: begin
                pixels_d = '0;
              end
            endcase
          end
        end
        OpCount, OpHit, OpSeek, OpBlank, OpHunt: begin
          pend_d   = 1'b1;
          frame_d  = '0;
          fstamp_d = time_i.now;
          case (op_e'(item_i.operation))
            OpCount: begin
              mode_d   = ModeCount;
              period_d = PeriodCount;
              color_d  = count_color(item_i.color_select);
              target_d = clamp_len;
            end
            OpHit: begin
              mode_d   = ModeHit;
              period_d = PeriodHit;
            end
            OpSeek: begin
              mode_d   = ModeSeek;
              period_d = PeriodSeek;
            end
            OpHunt: begin
              mode_d   = ModeHunt;
              period_d = PeriodHunt;
            end
            default: begin
              mode_d   = ModeBlank;
              period_d = PeriodBlank;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign pixels_o = pixels_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeBlank;
      frame_q  <= '0;
      fstamp_q <= '0;
      period_q <= PeriodBlank;
      pend_q   <= 1'b0;
      color_q  <= ColDark;
      target_q <= '0;
      pixels_q <= '0;
    end else begin
      mode_q   <= mode_d;
      frame_q  <= frame_d;
      fstamp_q <= fstamp_d;
      period_q <= period_d;
      pend_q   <= pend_d;
      color_q  <= color_d;
      target_q <= target_d;
      pixels_q <= pixels_d;
    end
  end

endmodule

FILE: hw/rtl/button_debounce_led_animator_top.sv
// ----------------------------------------------------------------------------
// button_debounce_led_animator_top
// button debouncer with press detection and an eight pixel strip animator
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry one item, either a one
//   millisecond tick with the raw button level or a command that starts an
//   animation; a transaction completes on an edge with valid high, stall low
// output channel: out_valid_o / out_stall_i carry exactly one result per
//   input item: press flags, repaint flag and the eight shown pixel words
// datapath: an item is captured in the input register, is processed in one
//   pass and its result is captured in the output register; throughput is
//   one item per cycle while the output is not stalled
// stall: while the output register is full and stalled the input register
//   holds and in_stall_o rises once it is occupied; no item is lost
// configuration: apb writes debounce_ms (0x0), long_press_ms (0x4); the user
//   must write only while the block is idle, unenforced; pready always high
// reset: time base, animation (blank mode) and pixels clear, the button reads as released,
//   registers return to 50 and 1000 ms; both channels come up empty
// ----------------------------------------------------------------------------
module button_debounce_led_animator_top import bdla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  cfg_t      cfg_q, cfg_d;

  logic      out_free;
  logic      process;
  logic      tick;
  logic      accept_in;
  logic      cfg_write;
  stamp_t    time_s;
  logic      short_press;
  logic      long_press;
  logic      updated;
  strip_t    pixels;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (paddr[2])
        RegDebounce:  cfg_d.debounce_ms   = pwdata[DebounceWidth-1:0];
        RegLongPress: cfg_d.long_press_ms = pwdata[LongPressWidth-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegDebounce:  prdata = DataWidth'(cfg_q.debounce_ms);
      RegLongPress: prdata = DataWidth'(cfg_q.long_press_ms);
      default:      prdata = '0;
    endcase
  end

  // flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign tick       = process && (op_e'(in_item_q.operation) == OpTick);

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (process) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  bdla_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .level_i       (in_item_q.button_level),
    .cfg_i         (cfg_q),
    .time_o        (time_s),
    .short_press_o (short_press),
    .long_press_o  (long_press)
  );

  bdla_animator u_animator (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (process),
    .item_i    (in_item_q),
    .time_i    (time_s),
    .updated_o (updated),
    .pixels_o  (pixels)
  );

  always_comb begin
    out_item_d.short_press   = short_press;
    out_item_d.long_press    = long_press;
    out_item_d.strip_updated = updated;
    out_item_d.pixel_0       = pixels[0];
    out_item_d.pixel_1       = pixels[1];
    out_item_d.pixel_2       = pixels[2];
    out_item_d.pixel_3       = pixels[3];
    out_item_d.pixel_4       = pixels[4];
    out_item_d.pixel_5       = pixels[5];
    out_item_d.pixel_6       = pixels[6];
    out_item_d.pixel_7       = pixels[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      cfg_q.debounce_ms   <= DebounceReset;
      cfg_q.long_press_ms <= LongPressReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_item_q <= in_data_i;
    end
    if (process) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && (op_e'(in_item_q.operation) != OpTick) |=>
      !out_item_q.short_press && !out_item_q.long_press && !out_item_q.strip_updated)
    else $error("command produced a tick result flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.short_press && out_item_q.long_press))
    else $error("short and long press flagged together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |=> out_valid_q && !$past(in_stall_o))
    else $error("processed item did not reach the output register");

endmodule

FILE: test/tb_button_debounce_led_animator_top.sv
// ----------------------------------------------------------------------------
// tb_button_debounce_led_animator_top
// self-checking bench of the button debounce and led animator block
// ----------------------------------------------------------------------------
// a scoreboard mirrors the debouncer, the press detector, the frame timer and
// the painting of every animation mode, and checks each result transaction
// field by field against the oldest prediction. directed commands cover the
// field range ends, every operation and the spare codes; long tick runs reach
// a debounce of 1000 ms, the seek frame wrap and a hunt frame step, and the
// registers are written and read back, zero among the values.
// random press sequences with contact bounce, commands and noise follow under
// four handshake pressure modes and several register settings
// ----------------------------------------------------------------------------
module tb_button_debounce_led_animator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bdla_pkg::*;

  localparam logic [2:0] OpSpareA      = 3'd6;
  localparam logic [2:0] OpSpareB      = 3'd7;
  localparam int         WatchdogLimit = 4000;
  localparam int         DrainCycles   = 8;

  class strip_scoreboard;
    logic [DebounceWidth-1:0]  debounce_ms;
    logic [LongPressWidth-1:0] long_press_ms;
    logic [TimeWidth-1:0]      now_ms;
    logic                      raw_level;
    logic                      steady_level;
    logic [TimeWidth-1:0]      change_ms;
    logic [TimeWidth-1:0]      press_ms;
    logic [TimeWidth-1:0]      frame_ms;
    logic [FrameWidth-1:0]     frame;
    logic [PeriodWidth-1:0]    period;
    mode_e                     mode;
    logic                      repaint_due;
    pixel_t                    bar_color;
    logic [3:0]                bar_target;
    pixel_t                    shown[LedCount];
    pixel_t                    palette[8];
    pixel_t                    hunt_cycle[3];
    out_item_t                 result_q[$];
    int                        n_fail;
    int                        n_in;
    int                        n_out;
    int                        n_short;
    int                        n_long;
    int                        n_repaint;

    function new();
      palette = '{ColRed, ColBlue, ColYellow, ColGreen, ColOrange, ColPurple, ColGrey,
                  ColGrey};
      hunt_cycle = '{ColRed, ColBlue, ColOrange};
      debounce_ms = DebounceReset;
      long_press_ms = LongPressReset;
      now_ms = '0;
      raw_level = 1'b1;
      steady_level = 1'b1;
      change_ms = '0;
      press_ms = '0;
      frame_ms = '0;
      frame = '0;
      period = PeriodBlank;
      mode = ModeBlank;
      repaint_due = 1'b0;
      bar_color = ColDark;
      bar_target = '0;
      foreach (shown[i]) shown[i] = ColDark;
      n_fail = 0;
      n_in = 0;
      n_out = 0;
      n_short = 0;
      n_long = 0;
      n_repaint = 0;
    endfunction

    function void set_reg(logic idx, logic [DataWidth-1:0] value);
      if (idx == RegDebounce) begin
        debounce_ms = value[DebounceWidth-1:0];
      end else begin
        long_press_ms = value[LongPressWidth-1:0];
      end
    endfunction

    function void start_mode(mode_e next_mode, logic [PeriodWidth-1:0] next_period);
      repaint_due = 1'b1;
      frame = '0;
      frame_ms = now_ms;
      period = next_period;
      mode = next_mode;
    endfunction

    function void paint();
      logic [3:0] lit;
      int         grp;
      case (mode)
        ModeCount: begin
          lit = (frame > FrameWidth'(bar_target)) ? bar_target : frame[3:0];
          foreach (shown[i]) shown[i] = (lit > i) ? bar_color : ColDark;
          repaint_due = 1'b1;
        end
        ModeHit: begin
          foreach (shown[i]) shown[i] = (frame == HitFirst || frame == HitSecond) ?
                                        ColYellow : ColDark;
        end
        ModeHunt: begin
          if (frame > HuntLast) frame = '0;
          foreach (shown[i]) begin
            grp = (i < 3) ? 0 : ((i < 5) ? 1 : 2);
            shown[i] = hunt_cycle[(grp + 3 - int'(frame)) % 3];
          end
        end
        ModeSeek: begin
          if (frame > SeekLast) frame = '0;
          foreach (shown[i]) begin
            shown[i] = (frame < SeekLast &&
                        (i == int'(frame) || int'(LedCount) - 1 - i == int'(frame))) ?
                       ColRed : ColWhite;
          end
        end
        default: begin
          foreach (shown[i]) shown[i] = ColDark;
        end
      endcase
    endfunction

    function void note_item(in_item_t item);
      out_item_t res;
      logic      level;
      res = '0;
      level = item.button_level;
      n_in++;
      case (item.operation)
        OpTick: begin
          now_ms = now_ms + 1'b1;
          if (level != raw_level) begin
            change_ms = now_ms;
            raw_level = level;
          end
          if (now_ms - change_ms > TimeWidth'(debounce_ms) && steady_level != level) begin
            steady_level = level;
            if (!level) begin
              res.short_press = 1'b1;
              press_ms = now_ms;
            end else if (now_ms - press_ms > TimeWidth'(long_press_ms)) begin
              res.long_press = 1'b1;
            end
          end
          if (now_ms - frame_ms >= TimeWidth'(period)) begin
            if (frame != FrameMax) frame++;
            frame_ms = now_ms;
            repaint_due = 1'b1;
          end
          if (repaint_due) begin
            repaint_due = 1'b0;
            res.strip_updated = 1'b1;
            paint();
          end
        end
        OpCount: begin
          start_mode(ModeCount, PeriodCount);
          bar_color = palette[item.color_select];
          if (item.bar_length[7]) begin
            bar_target = '0;
          end else if (item.bar_length >= 8) begin
            bar_target = 4'(LedCount);
          end else begin
            bar_target = item.bar_length[3:0];
          end
        end
        OpHit:   start_mode(ModeHit, PeriodHit);
        OpSeek:  start_mode(ModeSeek, PeriodSeek);
        OpBlank: start_mode(ModeBlank, PeriodBlank);
        OpHunt:  start_mode(ModeHunt, PeriodHunt);
        default: ;
      endcase
      res.pixel_0 = shown[0];
      res.pixel_1 = shown[1];
      res.pixel_2 = shown[2];
      res.pixel_3 = shown[3];
      res.pixel_4 = shown[4];
      res.pixel_5 = shown[5];
      res.pixel_6 = shown[6];
      res.pixel_7 = shown[7];
      if (res.short_press) n_short++;
      if (res.long_press) n_long++;
      if (res.strip_updated) n_repaint++;
      result_q.push_back(res);
    endfunction

    function void compare(string field, logic [ColorWidth-1:0] want,
                          logic [ColorWidth-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        n_fail++;
      end
    endfunction

    function void check_strip(out_item_t got);
      out_item_t want;
      n_out++;
      if (result_q.size() == 0) begin
        $error("result transaction with no input transaction waiting");
        n_fail++;
        return;
      end
      want = result_q.pop_front();
      compare("short_press", want.short_press, got.short_press);
      compare("long_press", want.long_press, got.long_press);
      compare("strip_updated", want.strip_updated, got.strip_updated);
      compare("pixel_0", want.pixel_0, got.pixel_0);
      compare("pixel_1", want.pixel_1, got.pixel_1);
      compare("pixel_2", want.pixel_2, got.pixel_2);
      compare("pixel_3", want.pixel_3, got.pixel_3);
      compare("pixel_4", want.pixel_4, got.pixel_4);
      compare("pixel_5", want.pixel_5, got.pixel_5);
      compare("pixel_6", want.pixel_6, got.pixel_6);
      compare("pixel_7", want.pixel_7, got.pixel_7);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  in_item_t                  in_data_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  out_item_t                 out_data_o;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [AddrWidth-1:0]      paddr = '0;
  logic [DataWidth-1:0]      pwdata = '0;
  logic [DataWidth-1:0]      prdata;
  logic                      pready;

  int                        idle_pct = 0;
  int                        stall_pct = 0;
  int                        n_sent = 0;
  int                        n_writes = 0;
  int                        quiet_cycles = 0;
  logic [DebounceWidth-1:0]  cur_debounce = DebounceReset;
  logic [LongPressWidth-1:0] cur_long = LongPressReset;
  strip_scoreboard           sb = new();

  button_debounce_led_animator_top u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_strip(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic in_item_t random_item();
    in_item_t item;
    item.operation = 3'($urandom_range(0, 7));
    item.button_level = 1'($urandom_range(0, 1));
    item.color_select = 3'($urandom_range(0, 7));
    item.bar_length = 8'($urandom_range(0, 255));
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.operation <= OpHunt) n_sent++;
  endtask

  task automatic send_command(input logic [2:0] op, input logic [2:0] color,
                              input logic signed [7:0] len);
    in_item_t item;
    item.operation = op;
    item.button_level = 1'($urandom_range(0, 1));
    item.color_select = color;
    item.bar_length = len;
    send_item(item);
  endtask

  task automatic random_command();
    send_command(3'($urandom_range(OpCount, OpHunt)), 3'($urandom_range(0, 7)),
                 8'($urandom_range(0, 255)));
  endtask

  task automatic run_level(input logic level, input int ticks);
    in_item_t item;
    repeat (ticks) begin
      item = random_item();
      item.operation = OpTick;
      item.button_level = level;
      send_item(item);
    end
  endtask

  task automatic bounce(input logic target);
    int span;
    int glitches;
    span = (cur_debounce == 0) ? 1 : int'(cur_debounce);
    glitches = $urandom_range(0, 3);
    repeat (glitches) begin
      run_level(target, $urandom_range(1, span));
      run_level(!target, $urandom_range(1, span));
    end
  endtask

  task automatic press_cycle();
    int lng;
    int hold;
    lng = int'(cur_long);
    bounce(1'b0);
    run_level(1'b0, int'(cur_debounce) + int'($urandom_range(1, 3)));
    if ($urandom_range(0, 1) == 0) begin
      hold = $urandom_range(1, lng + 1);
    end else begin
      hold = lng + int'($urandom_range(0, 5)) - 2;
      if (hold < 1) hold = 1;
    end
    if ($urandom_range(0, 3) == 0) random_command();
    run_level(1'b0, hold);
    bounce(1'b1);
    run_level(1'b1, int'(cur_debounce) + int'($urandom_range(1, 3)));
  endtask

  task automatic random_segment(input int quota);
    int stop_at;
    int pick;
    stop_at = n_sent + quota;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        press_cycle();
      end else if (pick < 80) begin
        random_command();
        run_level(1'b1, $urandom_range(1, 150));
      end else begin
        repeat ($urandom_range(1, 8)) send_item(random_item());
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [DataWidth-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    if (idx == RegDebounce) begin
      cur_debounce = value[DebounceWidth-1:0];
    end else begin
      cur_long = value[LongPressWidth-1:0];
    end
    n_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      $error("register read-back: expected 0x%0h, got 0x%0h", value, prdata);
      sb.n_fail++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: range ends, every operation, spare codes
    send_command(OpCount, 3'd0, -128);
    run_level(1'b1, 1);
    send_command(OpCount, 3'd7, 127);
    run_level(1'b0, 1);
    send_command(OpCount, 3'd5, 8);
    run_level(1'b1, 1);
    send_command(OpCount, 3'd6, 7);
    run_level(1'b0, 1);
    send_command(OpCount, 3'd1, -1);
    send_command(OpCount, 3'd2, 1);
    send_command(OpCount, 3'd3, 0);
    send_command(OpCount, 3'd4, 3);
    run_level(1'b1, 2);
    send_command(OpHit, 3'd0, 0);
    run_level(1'b1, 1);
    send_command(OpSeek, 3'd0, 0);
    run_level(1'b1, 1);
    send_command(OpBlank, 3'd0, 0);
    run_level(1'b1, 1);
    send_command(OpHunt, 3'd0, 0);
    run_level(1'b1, 1);
    send_command(OpSpareA, 3'd7, -128);
    send_command(OpSpareB, 3'd0, 127);
    run_level(1'b1, 1);

    // debounce of 1000 ms, seek frame wrap
    drain();
    reg_write(RegDebounce, 1000);
    reg_write(RegLongPress, 0);
    send_command(OpSeek, 3'd0, 0);
    run_level(1'b0, 1003);

    // hold limit of 10000 ms, a hunt frame step
    drain();
    reg_write(RegDebounce, 0);
    reg_write(RegLongPress, 10000);
    run_level(1'b1, 20);
    run_level(1'b0, 20);
    run_level(1'b1, 20);
    send_command(OpHunt, 3'd0, 0);
    run_level(1'b1, 310);

    for (int phase = 0; phase < 4; phase++) begin
      for (int part = 0; part < 2; part++) begin
        drain();
        if (phase == 0) begin
          idle_pct = 0;
          stall_pct = 0;
        end else if (phase == 1) begin
          idle_pct = 55;
          stall_pct = 0;
        end else if (phase == 2) begin
          idle_pct = 0;
          stall_pct = 55;
        end else begin
          idle_pct = 35;
          stall_pct = 35;
        end
        if (phase == 0 && part == 0) begin
          reg_write(RegDebounce, 0);
          reg_write(RegLongPress, 0);
        end else begin
          reg_write(RegDebounce, $urandom_range(0, 10));
          reg_write(RegLongPress, $urandom_range(0, 40));
        end
        random_segment(45);
      end
    end

    drain();
    $display("checked %0d results for %0d input transactions",
             sb.n_out, sb.n_in);
    $display("%0d short presses, %0d long presses, %0d repaints, %0d register writes",
             sb.n_short, sb.n_long, sb.n_repaint, n_writes);
    if (sb.n_fail == 0 && sb.result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
